>>> rtl/bpe_pkg.sv
package bpe_pkg;

   // Pipeline depth and the place of each step in it.
   localparam int NUM_STAGES = 27;
   localparam int ST_DIST    = 1;
   localparam int ST_SQ      = 2;
   localparam int ST_PREP    = 3;
   localparam int SPD_FIRST  = 1;
   localparam int SPD_LAST   = 12;
   localparam int DIV_FIRST  = 4;
   localparam int DIV_LAST   = 20;
   localparam int ST_SCALE   = 21;
   localparam int ST_SIGN    = 22;
   localparam int ST_SPD1    = 23;
   localparam int ST_LIN     = 24;
   localparam int ST_SPD2    = 25;
   localparam int ST_OUT     = 26;

   // Fitted model constants.
   localparam logic [10:0] LIN_GAIN      = 11'd1694;
   localparam logic [15:0] LIN_OFFSET    = 16'd574;
   localparam logic [15:0] CURVE_GAIN    = 16'd6027;
   localparam logic [15:0] CURVE_OFFSET  = 16'd3198;
   localparam logic [12:0] ARC_CENTER    = 13'd1123;
   localparam logic [24:0] ARC_SQUARE    = 25'd1261129;
   localparam logic [15:0] ARC_BIAS      = 16'd19706;
   localparam logic [15:0] MIN_PERIOD    = 16'h0060;
   localparam logic [18:0] SPEED_NUM     = 19'(128 * 2940);
   localparam logic [15:0] POWER_SCALE   = 16'd13;
   localparam logic [11:0] NEUTRAL_RESET = 12'd2048;

   // Everything one item carries down the pipeline.
   typedef struct packed {
      logic        zero;
      logic        neg;
      logic [15:0] per;
      logic [14:0] z1h;
      logic [11:0] delta;
      logic [23:0] sq;
      logic [15:0] dvs;
      logic [22:0] num;
      logic [15:0] mrem;
      logic [16:0] quo;
      logic [15:0] srem;
      logic [11:0] spd;
      logic [15:0] z2;
   } item_type;

   // One restoring step of the speed division: shifts in numerator bit k.
   function automatic item_type spd_step(item_type it, int k);
      item_type    res;
      logic [16:0] trial;
      logic [4:0]  nk;
      logic [3:0]  qk;
      res   = it;
      nk    = k[4:0];
      qk    = k[3:0];
      trial = {it.srem, SPEED_NUM[nk]};
      if (trial >= {1'b0, it.per}) begin
         res.srem    = 16'(trial - {1'b0, it.per});
         res.spd[qk] = 1'b1;
      end else begin
         res.srem    = trial[15:0];
         res.spd[qk] = 1'b0;
      end
      return res;
   endfunction

   // One restoring step of the curve division; the dividend is num shifted up by eight.
   function automatic item_type div_step(item_type it, int k);
      item_type    res;
      logic [16:0] trial;
      logic        dbit;
      int          sk;
      logic [4:0]  nk;
      logic [4:0]  qk;
      res   = it;
      sk    = (k >= 8) ? (k - 8) : 0;
      nk    = sk[4:0];
      qk    = k[4:0];
      dbit  = (k >= 8) ? it.num[nk] : 1'b0;
      trial = {it.mrem, dbit};
      if (trial >= {1'b0, it.dvs}) begin
         res.mrem    = 16'(trial - {1'b0, it.dvs});
         res.quo[qk] = 1'b1;
      end else begin
         res.mrem    = trial[15:0];
         res.quo[qk] = 1'b0;
      end
      return res;
   endfunction

endpackage

>>> rtl/brake_power_estimator.sv
// A beat accepted at the input passes through stage registers 0 to 26 in order and appears on rsp_tdata from the last.
// Throughput: one beat per cycle while rsp_tready is high, set by the 27 register stages; both dividers retire
// one quotient bit per stage, so no unit is shared between items.
// Back-pressure holds only the stages behind a stalled one, so bubbles are filled.
// Reset (synchronous, active high) empties every stage and sets the neutral level to 2048.
module brake_power_estimator
   import bpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [11:0] brake_level, [27:12] wheel_period, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] power_x13
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);

   logic [11:0]           neutral_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stall;
   item_type              stage_ff [NUM_STAGES];
   item_type              stage_in [NUM_STAGES];

   // Neutral level register.
   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_ff <= NEUTRAL_RESET;
      end else if (csr_wr_en) begin
         neutral_ff <= csr_wr_data;
      end
   end

   // First stage: period floor, linear term and distance from neutral.
   always_comb begin
      logic [11:0] lvl;
      logic [15:0] prd;
      logic [12:0] diff;
      logic [23:0] lin;
      logic [15:0] z1;
      lvl  = req_tdata[11:0];
      prd  = req_tdata[27:12];
      diff = {1'b0, lvl} - {1'b0, neutral_ff};
      lin  = 24'(lvl) * 24'(LIN_GAIN);
      z1   = lin[23:8] + LIN_OFFSET;
      stage_in[0]       = '0;
      stage_in[0].zero  = (prd == 16'd0);
      stage_in[0].per   = (prd > MIN_PERIOD) ? prd : MIN_PERIOD;
      stage_in[0].z1h   = z1[15:1];
      stage_in[0].neg   = diff[12];
      stage_in[0].delta = diff[12] ? 12'(13'd0 - diff) : diff[11:0];
      stage_in[0].srem  = 16'(SPEED_NUM[18:12]);
   end

   assign valid_in[0] = req_tvalid;

   // Later stages, each one step of the calculation.
   for (genvar i = 1; i < NUM_STAGES; i++) begin : g_step
      assign valid_in[i] = valid_ff[i-1];

      always_comb begin
         logic [31:0] prod;
         logic [12:0] t;
         logic [24:0] s;
         prod        = '0;
         t           = '0;
         s           = '0;
         stage_in[i] = stage_ff[i-1];

         // Distance from the arc centre, folded to a magnitude.
         if (i == ST_DIST) begin
            t = {1'b0, stage_ff[i-1].delta} - ARC_CENTER;
            stage_in[i].delta = t[12] ? 12'(13'd0 - t) : t[11:0];
         end

         // Squared distance.
         if (i == ST_SQ) begin
            prod = 32'(stage_ff[i-1].delta) * 32'(stage_ff[i-1].delta);
            stage_in[i].sq = prod[23:0];
         end

         // Divisor, numerator magnitude and the leading remainder of the curve division.
         if (i == ST_PREP) begin
            stage_in[i].dvs = stage_ff[i-1].sq[23:8] + ARC_BIAS;
            s = ARC_SQUARE - {1'b0, stage_ff[i-1].sq};
            if (s[24]) begin
               stage_in[i].num = 23'(25'd0 - s);
               stage_in[i].neg = ~stage_ff[i-1].neg;
            end else begin
               stage_in[i].num = s[22:0];
            end
            stage_in[i].mrem = 16'(stage_in[i].num[22:9]);
         end

         // Speed division, one quotient bit per stage.
         if (i >= SPD_FIRST && i <= SPD_LAST) begin
            stage_in[i] = spd_step(stage_in[i], SPD_LAST - i);
         end

         // Curve division, one quotient bit per stage.
         if (i >= DIV_FIRST && i <= DIV_LAST) begin
            stage_in[i] = div_step(stage_in[i], DIV_LAST - i);
         end

         // Curve scaling.
         if (i == ST_SCALE) begin
            prod = 32'(stage_ff[i-1].quo[15:0]) * 32'(CURVE_GAIN);
            stage_in[i].z2 = prod[31:16];
         end

         // Sign restore and offset.
         if (i == ST_SIGN) begin
            stage_in[i].z2 = (stage_ff[i-1].neg ? (16'd0 - stage_ff[i-1].z2)
                                                : stage_ff[i-1].z2) + CURVE_OFFSET;
         end

         // First speed product.
         if (i == ST_SPD1) begin
            prod = 32'(stage_ff[i-1].z2) * 32'(stage_ff[i-1].spd);
            stage_in[i].z2 = prod[24:9];
         end

         // Add half the linear term.
         if (i == ST_LIN) begin
            stage_in[i].z2 = stage_ff[i-1].z2 + {1'b0, stage_ff[i-1].z1h};
         end

         // Second speed product.
         if (i == ST_SPD2) begin
            prod = 32'(stage_ff[i-1].z2) * 32'(stage_ff[i-1].spd);
            stage_in[i].z2 = prod[31:16];
         end

         // Power scale; an unknown period gives zero.
         if (i == ST_OUT) begin
            prod = 32'(stage_ff[i-1].z2) * 32'(POWER_SCALE);
            stage_in[i].z2 = stage_ff[i-1].zero ? 16'd0 : prod[15:0];
         end
      end
   end

   // A stage holds only when it is full and the stage after it holds.
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      if (i == NUM_STAGES - 1) begin : g_last
         assign stall[i] = valid_ff[i] & ~rsp_tready;
      end else begin : g_mid
         assign stall[i] = valid_ff[i] & stall[i+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (!stall[i]) begin
            valid_ff[i] <= valid_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (!stall[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign req_tready = ~stall[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = stage_ff[NUM_STAGES-1].z2;

   // The input is refused only when every stage holds a beat.
   a_full_when_refused: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff))
      else $error("input refused while the pipeline has an empty stage");

   // The speed quotient stays within the range the period floor allows.
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[SPD_LAST] |-> (stage_ff[SPD_LAST].spd >= 12'd5 &&
                              stage_ff[SPD_LAST].spd <= 12'd3920))
      else $error("speed quotient out of range");

   // The curve division leaves a remainder below its divisor.
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_LAST] |-> (stage_ff[DIV_LAST].mrem < stage_ff[DIV_LAST].dvs))
      else $error("curve division remainder not below divisor");

   // A beat with an unknown period leaves as zero.
   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_OUT] && stage_ff[ST_OUT].zero) |-> (rsp_tdata == 16'd0))
      else $error("unknown period did not give zero power");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import bpe_pkg::*;

   localparam int PERIOD_NS    = 10;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = NUM_STAGES + 13;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 195;
   localparam int MAX_WAIT     = 10;

   // One request waiting for the driver, with the idle cycles to insert ahead of it.
   typedef struct {
      logic [11:0] level;
      logic [15:0] period;
      int          gap;
   } brake_request_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic [11:0] csr_wr_data = '0;

   brake_power_estimator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   brake_request_type brake_requests[$];
   logic [15:0]       power_due[$];
   logic [11:0]       neutral_copy = NEUTRAL_RESET;

   int fail_count     = 0;
   int beats_checked  = 0;
   int settings_count = 1;
   int zero_periods   = 0;
   int short_periods  = 0;
   int cycle_count    = 0;

   // Sender idle pattern: stretches of back-to-back beats between stretches with gaps.
   logic send_burst   = 1'b0;
   int   stretch_left = 0;

   // Driver and monitor working state, touched only inside their own blocks.
   brake_request_type held_request;
   logic              holding    = 1'b0;
   int                wait_left  = 0;
   logic              rsp_burst  = 1'b0;
   int                stall_left = 0;

   always #(PERIOD_NS / 2) clock = ~clock;

   // Expected power estimate for one request, with z1, z2, speed and the divisor wrapped at 16 bits.
   function automatic logic [15:0] predict_power(logic [11:0] level, logic [15:0] period,
                                                 logic [11:0] neutral);
      logic [15:0] per;
      logic [15:0] speed;
      logic [15:0] z1;
      logic [15:0] z2;
      logic [15:0] dvs;
      logic [31:0] prod;
      logic [31:0] sq;
      logic [31:0] unum;
      int          d;
      int          num;
      logic        neg;
      if (period == 16'd0) begin
         return 16'd0;
      end
      per   = (period > MIN_PERIOD) ? period : MIN_PERIOD;
      speed = 16'(32'(SPEED_NUM) / 32'(per));

      // Linear force term.
      prod = 32'(level) * 32'(LIN_GAIN);
      z1   = 16'(prod >> 8);
      z1   = z1 + LIN_OFFSET;

      // Distance from neutral, with the side of neutral kept as a sign.
      neg = 1'b0;
      d   = int'(level) - int'(neutral);
      if (d < 0) begin
         d   = -d;
         neg = 1'b1;
      end
      d = d - int'(ARC_CENTER);
      if (d < 0) begin
         d = -d;
      end

      // Curved term: squared distance over a biased divisor.
      sq  = 32'(d) * 32'(d);
      dvs = 16'(sq >> 8);
      dvs = dvs + ARC_BIAS;
      num = int'(ARC_SQUARE) - int'(sq);
      if (num < 0) begin
         num = -num;
         neg = ~neg;
      end
      unum = 32'(num) << 8;
      z2   = (dvs != 16'd0) ? 16'(unum / 32'(dvs)) : 16'hFFFF;

      // Scaling, sign restore and offset.
      prod = 32'(z2) * 32'(CURVE_GAIN);
      z2   = 16'(prod >> 16);
      if (neg) begin
         z2 = -z2;
      end
      z2 = z2 + CURVE_OFFSET;

      // Speed enters twice.
      prod = 32'(z2) * 32'(speed);
      z2   = 16'(prod >> 9);
      z1   = z1 >> 1;
      z2   = z2 + z1;
      prod = 32'(z2) * 32'(speed);
      z2   = 16'(prod >> 16);
      prod = 32'(z2) * 32'(POWER_SCALE);
      return prod[15:0];
   endfunction

   function automatic logic [11:0] clip_level(int v);
      if (v < 0) begin
         return 12'd0;
      end
      if (v > 4095) begin
         return 12'hFFF;
      end
      return 12'(v);
   endfunction

   // Queue one request and draw the idle cycles that come before it.
   task automatic queue_request(logic [11:0] level, logic [15:0] period);
      brake_request_type r;
      stretch_left = stretch_left - 1;
      if (stretch_left <= 0) begin
         send_burst   = ($urandom_range(0, 2) == 0);
         stretch_left = $urandom_range(20, 80);
      end
      r.level  = level;
      r.period = period;
      r.gap    = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (period == 16'd0) begin
         zero_periods++;
      end else if (period < MIN_PERIOD) begin
         short_periods++;
      end
      brake_requests.push_back(r);
   endtask

   // Random request, weighted towards the bends of the fitted curve.
   task automatic queue_random_request();
      int          jitter;
      int          side;
      logic [11:0] level;
      logic [15:0] period;
      jitter = $urandom_range(0, 8);
      jitter = jitter - 4;
      side   = ($urandom_range(0, 1) == 1) ? 1 : -1;
      case ($urandom_range(0, 11))
         0: begin
            level = 12'd0;
         end
         1: begin
            level = 12'hFFF;
         end
         2, 3: begin
            level = clip_level(int'(neutral_copy) + side * int'(ARC_CENTER) + jitter);
         end
         4: begin
            level = clip_level(int'(neutral_copy) + side * 2 * int'(ARC_CENTER) + jitter);
         end
         5: begin
            level = clip_level(int'(neutral_copy) + jitter);
         end
         default: begin
            level = 12'($urandom());
         end
      endcase
      case ($urandom_range(0, 9))
         0: begin
            period = 16'd0;
         end
         1: begin
            period = 16'($urandom_range(1, 96));
         end
         2, 3: begin
            period = 16'($urandom_range(96, 2000));
         end
         4: begin
            period = 16'hFFFF;
         end
         default: begin
            period = 16'($urandom());
         end
      endcase
      queue_request(level, period);
   endtask

   // Wait until every request has gone in and every result has come back.
   task automatic wait_for_idle();
      while (brake_requests.size() != 0 || holding || req_tvalid || power_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_neutral(logic [11:0] value);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= value;
      neutral_copy = value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   // Request driver: presents one beat at a time after its drawn idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         holding    = 1'b0;
         wait_left  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            power_due.push_back(predict_power(req_tdata[11:0], req_tdata[27:12],
                                              neutral_copy));
         end
         if (!req_tvalid || req_tready) begin
            if (!holding && brake_requests.size() != 0) begin
               held_request = brake_requests.pop_front();
               holding      = 1'b1;
               wait_left    = held_request.gap;
            end
            if (holding && wait_left == 0) begin
               req_tdata  <= {4'd0, held_request.period, held_request.level};
               req_tvalid <= 1'b1;
               holding    = 1'b0;
            end else begin
               req_tvalid <= 1'b0;
               if (holding) begin
                  wait_left = wait_left - 1;
               end
            end
         end
      end
   end

   // Result monitor: checks each beat against the oldest prediction and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (power_due.size() == 0) begin
               $error("power_x13: no result expected, actual %0d", rsp_tdata);
               fail_count++;
            end else begin
               if (rsp_tdata !== power_due[0]) begin
                  $error("power_x13: expected %0d, actual %0d", power_due[0], rsp_tdata);
                  fail_count++;
               end
               void'(power_due.pop_front());
               beats_checked++;
            end
            if ($urandom_range(0, 59) == 0) begin
               rsp_burst = ~rsp_burst;
            end
            stall_left = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("brake_power_estimator: mismatch");
         $finish;
      end
   end

   // Stimulus: directed corners at the reset neutral level, then random phases.
   initial begin
      logic [11:0] neutral_list[8];
      neutral_list = '{12'd0, 12'hFFF, 12'd1123, 12'd3171,
                       12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom())};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unknown, floored and extreme periods around the arc points of the reset level.
      queue_request(12'd2048, 16'd0);
      queue_request(12'd1000, 16'd0);
      queue_request(12'd0, 16'd1);
      queue_request(12'hFFF, 16'hFFFF);
      queue_request(12'd2048, 16'd96);
      queue_request(clip_level(int'(neutral_copy) - int'(ARC_CENTER)), 16'd95);
      queue_request(clip_level(int'(neutral_copy) + int'(ARC_CENTER)), 16'd97);
      queue_request(clip_level(int'(neutral_copy) - int'(ARC_CENTER) - 1), 16'd3000);
      queue_request(clip_level(int'(neutral_copy) + int'(ARC_CENTER) + 1), 16'd200);
      queue_request(12'd2047, 16'd150);
      queue_request(12'hFFF, 16'd96);
      queue_request(12'd0, 16'hFFFF);
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         queue_random_request();
      end
      wait_for_idle();

      for (int p = 0; p < 8; p++) begin
         write_neutral(neutral_list[p]);
         if (p == 0) begin
            // Far from neutral the curved numerator changes sign.
            queue_request(12'd2246, 16'd500);
            queue_request(12'd2247, 16'd500);
            queue_request(12'hFFF, 16'd96);
            queue_request(12'd0, 16'd1);
            queue_request(12'd1123, 16'hFFFF);
         end
         for (int i = 0; i < RANDOM_BEATS; i++) begin
            queue_random_request();
         end
         wait_for_idle();
      end

      $display("Checked %0d result beats over %0d neutral-level settings.",
               beats_checked, settings_count);
      $display("Requests with unknown period: %0d, with period below the floor: %0d.",
               zero_periods, short_periods);
      if (fail_count == 0 && power_due.size() == 0) begin
         $display("brake_power_estimator: match");
      end else begin
         $display("brake_power_estimator: mismatch");
      end
      $finish;
   end

endmodule
